### hdl/sorted_topk_insert_list_defines.svh
// ============================================================================
// sorted_topk_insert_list_defines
// assertion macros shared by the sorted top-k list rtl
// ============================================================================
`ifndef SORTED_TOPK_INSERT_LIST_DEFINES_SVH
`define SORTED_TOPK_INSERT_LIST_DEFINES_SVH

`ifndef SYNTH

// property must hold at every edge outside reset
`define STIK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define STIK_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define STIK_ASSERT(lbl, clk, rst, prop, msg)
`define STIK_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

### hdl/stik_pkg.sv
// ============================================================================
// stik_pkg
// types and constants for the sorted top-k insertion list
// ============================================================================
package stik_pkg;

   localparam int KEY_W      = 32;
   localparam int TAG_W      = 16;
   localparam int SLOT_W     = 4;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_COUNT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_ORDER = 4'd1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 5'd16;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic clear;
      logic reverse;
   } cell_ctrl_type;

   typedef struct packed {
      logic found;
      logic first;
   } cell_stat_type;

endpackage

### hdl/stik_cell.sv
// ============================================================================
// stik_cell
// one list slot: compares the incoming key, takes it, takes the neighbour's
// entry, clears or holds, and passes the found flag on down the chain
// ============================================================================
module stik_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stik_pkg::cell_ctrl_type ctrl,
   input  logic                  in_use,
   input  stik_pkg::entry_type   new_entry,
   input  stik_pkg::entry_type   prev_entry,
   input  logic                  found_in,
   output stik_pkg::entry_type   entry,
   output stik_pkg::cell_stat_type stat
);
   import stik_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      beats;
   logic      hit;

   always_comb begin
      if (ctrl.reverse) begin
         beats = new_entry.key < entry_ff.key;
      end else begin
         beats = entry_ff.key < new_entry.key;
      end
      // an empty slot takes any key
      hit = in_use && (beats || (entry_ff.key == '0));
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in = '0;
      end else if (ctrl.insert && in_use) begin
         if (found_in) begin
            entry_in = prev_entry;
         end else if (hit) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry      = entry_ff;
   assign stat.found = found_in | hit;
   assign stat.first = hit & ~found_in;

endmodule

### hdl/sorted_topk_insert_list.sv
// ============================================================================
// sorted_topk_insert_list
// sorted list of up to DEPTH (key, tag) pairs held in a chain of slot cells
// ============================================================================
// rsp_valid strobes in the cycle after start, for insert and read
// throughput: one beat per cycle; busy stays low, every cell compares and shifts
//   in the same cycle, limited by the found chain running through all cells
// reset: synchronous, clears every slot, entry_count back to 16, descending
// a write to entry_count clears every slot at the clock edge that ends the write
// the receiver cannot stall: each result is shown for exactly one cycle
module sorted_topk_insert_list #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [stik_pkg::KEY_W-1:0]   req_score,
   input  logic [stik_pkg::TAG_W-1:0]          req_name_tag,
   input  logic [stik_pkg::SLOT_W-1:0]         req_slot,
   output logic                                rsp_valid,
   output logic                                rsp_placed,
   output logic [stik_pkg::SLOT_W-1:0]         rsp_position,
   output logic signed [stik_pkg::KEY_W-1:0]   rsp_read_score,
   output logic [stik_pkg::TAG_W-1:0]          rsp_read_name,
   input  logic                                csr_we,
   input  logic [stik_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stik_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import stik_pkg::*;

`include "sorted_topk_insert_list_defines.svh"

   localparam int SLOT_RANGE = 1 << SLOT_W;

   logic [CNT_W-1:0]  entry_count_ff;
   logic [CNT_W-1:0]  entry_count_in;
   logic              reverse_ff;
   logic              reverse_in;

   logic              accept;
   cell_ctrl_type     ctrl;
   entry_type         new_entry;
   entry_type         cell_entry [DEPTH];
   cell_stat_type     cell_stat  [DEPTH];
   logic [DEPTH-1:0]  in_use;

   logic [SLOT_W-1:0] position;
   entry_type         read_entry;

   logic              rsp_valid_ff;
   logic              rsp_placed_ff;
   logic [SLOT_W-1:0] rsp_position_ff;
   entry_type         rsp_read_ff;
   logic              rsp_placed_in;
   logic [SLOT_W-1:0] rsp_position_in;
   entry_type         rsp_read_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_comb begin
      entry_count_in = entry_count_ff;
      reverse_in     = reverse_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ENTRY_COUNT:   entry_count_in = csr_wdata;
            REG_REVERSE_ORDER: reverse_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RST;
         reverse_ff     <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         reverse_ff     <= reverse_in;
      end
   end

   assign ctrl.insert   = accept && (req_op == OP_INSERT);
   assign ctrl.clear    = csr_we && (csr_index == REG_ENTRY_COUNT);
   assign ctrl.reverse  = reverse_ff;
   assign new_entry.key = req_score;
   assign new_entry.tag = req_name_tag;

   // ---------------------------------------------------------------------
   // cell chain
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // a count above the depth simply covers every cell
      assign in_use[i] = int'(entry_count_ff) > i;

      if (i == 0) begin : g_head
         stik_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .in_use     (in_use[i]),
            .new_entry  (new_entry),
            .prev_entry (new_entry),
            .found_in   (1'b0),
            .entry      (cell_entry[i]),
            .stat       (cell_stat[i])
         );
      end else begin : g_body
         stik_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .in_use     (in_use[i]),
            .new_entry  (new_entry),
            .prev_entry (cell_entry[i-1]),
            .found_in   (cell_stat[i-1].found),
            .entry      (cell_entry[i]),
            .stat       (cell_stat[i])
         );
      end
   end

   // ---------------------------------------------------------------------
   // position encode and read select
   // ---------------------------------------------------------------------
   always_comb begin
      position   = '0;
      read_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_stat[i].first) begin
            position = position | SLOT_W'(i);
         end
         if ((i < SLOT_RANGE) && (req_slot == SLOT_W'(i)) && in_use[i]) begin
            read_entry = read_entry | cell_entry[i];
         end
      end
   end

   always_comb begin
      rsp_placed_in   = 1'b0;
      rsp_position_in = '0;
      rsp_read_in     = '0;
      if (req_op == OP_READ) begin
         rsp_read_in = read_entry;
      end else if (cell_stat[DEPTH-1].found) begin
         rsp_placed_in   = 1'b1;
         rsp_position_in = position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_placed_ff   <= rsp_placed_in;
         rsp_position_ff <= rsp_position_in;
         rsp_read_ff     <= rsp_read_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_placed     = rsp_placed_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_read_score = rsp_read_ff.key;
   assign rsp_read_name  = rsp_read_ff.tag;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `STIK_ASSERT(a_one_rsp_per_beat, clock, reset, accept |=> rsp_valid, "beat gave no result")
   `STIK_ASSERT(a_no_stray_rsp, clock, reset, rsp_valid |-> $past(accept), "result without a beat")
   `STIK_ASSERT(a_placed_on_insert, clock, reset, (rsp_valid && rsp_placed) |-> ($past(req_op) == OP_INSERT), "read reported as placed")
   `STIK_ASSERT(a_count_write_clears, clock, reset, ctrl.clear |=> (cell_entry[0] == '0), "count write left slot 0 filled")
   `STIK_ASSERT_NEVER(a_read_on_insert, clock, reset, rsp_valid && ($past(req_op) == OP_INSERT) && (rsp_read_score != '0), "insert returned read data")

endmodule
